// ----- hdl/frhc_pkg.sv -----
// Shared types, constants and CRC helpers for the frame header / CRC checker.
// No dependencies; used by frhc_tracker and frame_header_crc_checker.
`default_nettype none

package frhc_pkg;

  // Frame layout
  localparam int HDR_CRC_SPAN = 15;  // bytes covered by the header CRC16
  localparam int HDR_SIZE     = 17;  // header including its CRC16
  localparam int TRAILER_SIZE = 4;   // trailing CRC-32
  localparam int MIN_FRAME    = HDR_SIZE + TRAILER_SIZE;

  // Byte counter
  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  // Byte offsets of header fields
  localparam int OFS_FLAGS = 4;
  localparam int OFS_SRC   = 5;
  localparam int OFS_DST   = 6;
  localparam int OFS_TYPE  = 7;
  localparam int OFS_ID    = 9;
  localparam int OFS_SEQ   = 11;
  localparam int OFS_PLEN  = 13;

  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam logic [31:0] CRC32_POLY = 32'hEDB88320;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC_FIRST     = 2'd0,
    CFG_MAGIC_SECOND    = 2'd1,
    CFG_MAJOR_VERSION   = 2'd2,
    CFG_HEADER_CRC_INIT = 2'd3
  } cfg_idx_t;

  localparam logic [15:0] HEADER_CRC_INIT_RST = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [7:0]  major_version;
    logic [15:0] header_crc_init;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_MAGIC     = 3'd2,
    ST_VERSION   = 3'd3,
    ST_HDR_CRC   = 3'd4,
    ST_LENGTH    = 3'd5,
    ST_FRAME_CRC = 3'd6
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [7:0]  flag_bits;
    logic [7:0]  source_node;
    logic [7:0]  dest_node;
    logic [15:0] message_type;
    logic [15:0] message_id;
    logic [15:0] sequence_number;
    logic [15:0] payload_length;
  } out_t;

  // CRC16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // CRC-32 reflected, one byte
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/frhc_tracker.sv -----
// Per-frame state of the checker: byte counter, header capture, both CRCs,
// trailer window and the verdict / payload result logic. Uses frhc_pkg.
`default_nettype none

module frhc_tracker (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire frhc_pkg::in_t  item,
  input  wire frhc_pkg::cfg_t cfg,
  output frhc_pkg::out_t     result,
  output logic               has_result
);

  logic [frhc_pkg::POS_W-1:0] pos;
  logic [7:0]                 hdr [frhc_pkg::HDR_CRC_SPAN];
  logic [15:0]                rx_crc;
  logic [15:0]                hcrc;
  logic [31:0]                fcrc;
  logic [31:0]                trailer;
  logic [2:0]                 flags;

  logic [frhc_pkg::POS_W-1:0] pos_next;
  logic [7:0]                 hdr_next [frhc_pkg::HDR_CRC_SPAN];
  logic [15:0]                rx_crc_next;
  logic [15:0]                hcrc_next;
  logic [31:0]                fcrc_next;
  logic [31:0]                trailer_next;
  logic [2:0]                 flags_next;
  logic [15:0]                plen;
  logic [frhc_pkg::POS_W:0]   full_len;
  logic [frhc_pkg::POS_W:0]   payload_end;
  logic                       in_payload;
  logic [7:0]                 b;

  assign b = item.data_byte;

  // state after this byte
  always_comb begin
    for (int k = 0; k < frhc_pkg::HDR_CRC_SPAN; k++) begin
      hdr_next[k] = (pos == frhc_pkg::POS_W'(k)) ? b : hdr[k];
    end

    hcrc_next = hcrc;
    if (pos < frhc_pkg::POS_W'(frhc_pkg::HDR_CRC_SPAN)) begin
      hcrc_next = frhc_pkg::crc16_byte(hcrc, b);
    end

    rx_crc_next = rx_crc;
    if (pos == frhc_pkg::POS_W'(frhc_pkg::HDR_CRC_SPAN)) begin
      rx_crc_next = {rx_crc[15:8], b};
    end else if (pos == frhc_pkg::POS_W'(frhc_pkg::HDR_CRC_SPAN + 1)) begin
      rx_crc_next = {b, rx_crc[7:0]};
    end

    flags_next = flags;
    if (pos == frhc_pkg::POS_W'(0) && b != cfg.magic_first) begin
      flags_next[0] = 1'b1;
    end
    if (pos == frhc_pkg::POS_W'(1) && b != cfg.magic_second) begin
      flags_next[1] = 1'b1;
    end
    if (pos == frhc_pkg::POS_W'(2) && b != cfg.major_version) begin
      flags_next[2] = 1'b1;
    end

    // frame CRC lags four bytes behind so the trailer never enters it
    fcrc_next = fcrc;
    if (pos >= frhc_pkg::POS_W'(frhc_pkg::TRAILER_SIZE)) begin
      fcrc_next = frhc_pkg::crc32_byte(fcrc, trailer[7:0]);
    end
    trailer_next = {b, trailer[31:8]};

    pos_next = (pos < frhc_pkg::POS_MAX) ? pos + frhc_pkg::POS_W'(1) : pos;
  end

  assign plen        = {hdr_next[frhc_pkg::OFS_PLEN + 1], hdr_next[frhc_pkg::OFS_PLEN]};
  assign full_len    = (frhc_pkg::POS_W + 1)'(frhc_pkg::MIN_FRAME) + {2'b00, plen};
  assign payload_end = (frhc_pkg::POS_W + 1)'(frhc_pkg::HDR_SIZE) + {2'b00, plen};
  assign in_payload  = (pos >= frhc_pkg::POS_W'(frhc_pkg::HDR_SIZE)) &&
                       ({1'b0, pos} < payload_end);

  // result for this byte
  always_comb begin
    result     = '0;
    has_result = 1'b0;
    if (item.last_byte) begin
      has_result = 1'b1;
      result.kind = frhc_pkg::KIND_VERDICT;
      if (pos_next < frhc_pkg::POS_W'(frhc_pkg::MIN_FRAME)) begin
        result.status = frhc_pkg::ST_SHORT;
      end else if (flags_next[1:0] != 2'b00) begin
        result.status = frhc_pkg::ST_MAGIC;
      end else if (flags_next[2]) begin
        result.status = frhc_pkg::ST_VERSION;
      end else if (hcrc_next != rx_crc_next) begin
        result.status = frhc_pkg::ST_HDR_CRC;
      end else if ({1'b0, pos_next} != full_len) begin
        result.status = frhc_pkg::ST_LENGTH;
      end else if (~fcrc_next != trailer_next) begin
        result.status = frhc_pkg::ST_FRAME_CRC;
      end else begin
        result.status = frhc_pkg::ST_OK;
      end
      result.flag_bits       = hdr_next[frhc_pkg::OFS_FLAGS];
      result.source_node     = hdr_next[frhc_pkg::OFS_SRC];
      result.dest_node       = hdr_next[frhc_pkg::OFS_DST];
      result.message_type    = {hdr_next[frhc_pkg::OFS_TYPE + 1], hdr_next[frhc_pkg::OFS_TYPE]};
      result.message_id      = {hdr_next[frhc_pkg::OFS_ID + 1], hdr_next[frhc_pkg::OFS_ID]};
      result.sequence_number = {hdr_next[frhc_pkg::OFS_SEQ + 1], hdr_next[frhc_pkg::OFS_SEQ]};
      result.payload_length  = plen;
    end else if (in_payload) begin
      has_result = 1'b1;
      result.kind         = frhc_pkg::KIND_PAYLOAD;
      result.payload_byte = b;
    end
  end

  // frame state; the last byte clears it for the next frame
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      rx_crc  <= '0;
      hcrc    <= frhc_pkg::HEADER_CRC_INIT_RST;
      fcrc    <= '1;
      trailer <= '0;
      flags   <= '0;
      for (int k = 0; k < frhc_pkg::HDR_CRC_SPAN; k++) begin
        hdr[k] <= '0;
      end
    end else if (step) begin
      if (item.last_byte) begin
        pos     <= '0;
        rx_crc  <= '0;
        hcrc    <= cfg.header_crc_init;
        fcrc    <= '1;
        trailer <= '0;
        flags   <= '0;
        for (int k = 0; k < frhc_pkg::HDR_CRC_SPAN; k++) begin
          hdr[k] <= '0;
        end
      end else begin
        pos     <= pos_next;
        rx_crc  <= rx_crc_next;
        hcrc    <= hcrc_next;
        fcrc    <= fcrc_next;
        trailer <= trailer_next;
        flags   <= flags_next;
        for (int k = 0; k < frhc_pkg::HDR_CRC_SPAN; k++) begin
          hdr[k] <= hdr_next[k];
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/frame_header_crc_checker.sv -----
// Top level of the frame header / CRC checker: input register, config
// registers, output register. Uses frhc_pkg and frhc_tracker.
//
// Usage:
//   Input channel (byte_valid / byte_stall / byte_data): one decoded frame
//   byte per request, last_byte set on the final byte of a frame.
//   Output channel (result_valid / result_stall / result_data): a payload
//   byte request (kind 0) for each byte inside the announced payload range,
//   and one verdict request (kind 1) on the last byte with status and the
//   header fields. Bytes outside the payload range give no request.
//   Config port (cfg_write / cfg_index / cfg_data): magic bytes, major
//   version, header CRC16 start value. Write only while the block is idle.
//   A new header CRC start value applies from the frame after the next
//   frame boundary, since the running CRC is seeded when a frame closes.
// Timing:
//   One byte per cycle sustained while result_stall is low. A byte lands
//   in the input register when accepted; the combinational CRC/check logic
//   then loads its result into the output register, where it is taken.
//   When result_stall is high with a result held, the pipeline freezes and
//   byte_stall rises once the input register is occupied; nothing is lost.
// Reset (rst, synchronous): clears both pipeline valids, the frame state,
//   and sets the config to its defaults (header CRC start 0xFFFF).
`default_nettype none

module frame_header_crc_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config
  input  wire logic                          cfg_write,
  input  wire logic [frhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [frhc_pkg::CFG_W-1:0]     cfg_data,
  // byte input
  input  wire logic                          byte_valid,
  output logic                               byte_stall,
  input  wire frhc_pkg::in_t                 byte_data,
  // results
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output frhc_pkg::out_t                     result_data
);

  frhc_pkg::cfg_t cfg;

  // input register
  logic           in_valid;
  frhc_pkg::in_t  in_item;

  logic           out_ready;
  logic           step;
  frhc_pkg::out_t result;
  logic           has_result;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first     <= '0;
      cfg.magic_second    <= '0;
      cfg.major_version   <= '0;
      cfg.header_crc_init <= frhc_pkg::HEADER_CRC_INIT_RST;
    end else if (cfg_write) begin
      case (frhc_pkg::cfg_idx_t'(cfg_index))
        frhc_pkg::CFG_MAGIC_FIRST:     cfg.magic_first     <= cfg_data[7:0];
        frhc_pkg::CFG_MAGIC_SECOND:    cfg.magic_second    <= cfg_data[7:0];
        frhc_pkg::CFG_MAJOR_VERSION:   cfg.major_version   <= cfg_data[7:0];
        frhc_pkg::CFG_HEADER_CRC_INIT: cfg.header_crc_init <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // output register can load when empty or being drained
  assign out_ready  = !result_valid || !result_stall;
  assign step       = in_valid && out_ready;
  assign byte_stall = in_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!byte_stall) begin
      in_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      in_item <= byte_data;
    end
  end

  frhc_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (in_item),
    .cfg        (cfg),
    .result     (result),
    .has_result (has_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_ready) begin
      result_valid <= step && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && step) begin
      result_data <= result;
    end
  end

endmodule

`default_nettype wire
